[rtl/fr_pkg.sv]
// ----------------------------------------------------------------------------
// fr_pkg
// Shared constants for the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

  // Default fraction bits of the direction and normal components.
  localparam int VEC_FRAC_BITS_DEF = 14;

  // Quotient bits of the refraction divide and root bits of the cosine.
  localparam int Q_BITS    = 30;
  localparam int ROOT_BITS = 31;

  // 1.0 in Q30 and in the Q1.16 result.
  localparam logic [30:0] ONE30    = 31'h4000_0000;
  localparam logic [16:0] REFL_ONE = 17'h1_0000;

endpackage

[rtl/fr_div.sv]
// ----------------------------------------------------------------------------
// fr_div
// Pipelined restoring divider, one quotient bit per stage, with a side word.
// ----------------------------------------------------------------------------
module fr_div #(
  parameter int DW = 34,
  parameter int QB = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] div_in,
  input  logic [QB-1:0] low_in,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QB-1:0] quot,
  output logic [SW-1:0] side_out
);

  // The starting remainder must be below the divisor; every stage keeps it so.
  logic [QB:0]   vld;
  logic [DW-1:0] rem  [QB+1];
  logic [DW-1:0] dv   [QB+1];
  logic [QB-1:0] lo   [QB+1];
  logic [QB-1:0] qt   [QB+1];
  logic [SW-1:0] sd   [QB+1];

  assign vld[0] = in_valid;
  assign rem[0] = rem_in;
  assign dv[0]  = div_in;
  assign lo[0]  = low_in;
  assign qt[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[i], lo[i][QB-1]};
      diff  = trial - {1'b0, dv[i]};
      ge    = trial >= {1'b0, dv[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        dv[i+1]  <= dv[i];
        lo[i+1]  <= {lo[i][QB-2:0], 1'b0};
        qt[i+1]  <= {qt[i][QB-2:0], ge};
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[QB];
  assign quot      = qt[QB];
  assign side_out  = sd[QB];

endmodule

[rtl/fr_sqrt.sv]
// ----------------------------------------------------------------------------
// fr_sqrt
// Pipelined integer square root, one root bit per stage, with a side word.
// ----------------------------------------------------------------------------
module fr_sqrt #(
  parameter int RB = 31,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RB-1:0] rad_in,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RB-1:0]   root,
  output logic [SW-1:0]   side_out
);

  localparam int RW = RB + 2;

  logic [RB:0]     vld;
  logic [RW-1:0]   rem [RB+1];
  logic [RB-1:0]   rt  [RB+1];
  logic [2*RB-1:0] rd  [RB+1];
  logic [SW-1:0]   sd  [RB+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rd[0]  = rad_in;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;

    always_comb begin
      t     = {rem[i], rd[i][2*RB-1:2*RB-2]};
      trial = (RW+2)'({rt[i], 2'b01});
      diff  = t - trial;
      ge    = t >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1] <= ge ? diff[RW-1:0] : t[RW-1:0];
        rt[i+1]  <= {rt[i][RB-2:0], ge};
        rd[i+1]  <= {rd[i][2*RB-3:0], 2'b00};
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[RB];
  assign root      = rt[RB];
  assign side_out  = sd[RB];

endmodule

[rtl/fresnel_reflectance_top.sv]
// ----------------------------------------------------------------------------
// fresnel_reflectance_top
// Dielectric Fresnel reflectance of one ray-surface hit per request.
// ----------------------------------------------------------------------------
// The block takes one request in every cycle while in_stall is low and
// returns its reflectance in order. The datapath is built from the three bit-serial
// pipelines: a 30-stage divider for the refracted sine, a 31-stage square
// root for the transmitted cosine and two parallel 31-stage dividers for the
// polarised coefficients, plus eleven stages of multiplies and adds. A stall
// on the output freezes the whole pipeline, so nothing is lost or repeated.
module fresnel_reflectance_top
  import fr_pkg::*;
#(
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic        [14:0] index_ratio,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [16:0] reflectance
);

  localparam int FB2 = 2 * VEC_FRAC_BITS;
  localparam int MW  = (FB2 + 1 > 34) ? FB2 + 1 : 34;
  localparam logic [MW-1:0] ONE2 = MW'(1) << FB2;

  typedef struct packed {
    logic [30:0] c;
    logic [14:0] n;
    logic        leaving;
    logic        tir;
    logic [29:0] qlv;
  } div1_side_t;

  typedef struct packed {
    logic [30:0] c;
    logic [14:0] n;
    logic        tir;
  } root_side_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: component products.
  logic               v1;
  logic signed [31:0] p0, p1, p2;
  logic        [14:0] n1;
  // Stage 2: dot product.
  logic               v2;
  logic signed [33:0] dot2;
  logic        [14:0] n2r;
  // Stage 3: clamped cosine in Q30.
  logic               v3, lv3;
  logic        [30:0] c3;
  logic        [14:0] n3;
  // Stage 4: squares.
  logic               v4, lv4;
  logic        [61:0] cc4;
  logic        [29:0] nn4;
  logic        [30:0] c4;
  logic        [14:0] n4;
  // Stage 5: squared sine.
  logic               v5, lv5;
  logic        [30:0] s5, c5;
  logic        [29:0] nn5;
  logic        [14:0] n5;
  // Stage 6: leaving-side product and entering-side reflection test.
  logic               v6, lv6, te6;
  logic        [60:0] sn6;
  logic        [30:0] s6, c6;
  logic        [29:0] nn6;
  logic        [14:0] n6;

  logic [MW-1:0] mag_ext, mag_cl;
  logic [33:0]   mag3;
  logic [30:0]   c_conv;

  always_comb begin
    mag3    = dot2[33] ? 34'(-dot2) : 34'(dot2);
    mag_ext = MW'(mag3);
    mag_cl  = (mag_ext > ONE2) ? ONE2 : mag_ext;
  end

  if (FB2 >= 30) begin : g_shr
    assign c_conv = 31'(mag_cl >> (FB2 - 30));
  end else begin : g_shl
    assign c_conv = 31'(mag_cl) << (30 - FB2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
    if (en) begin
      p0   <= 32'(dir_x * norm_x);
      p1   <= 32'(dir_y * norm_y);
      p2   <= 32'(dir_z * norm_z);
      n1   <= index_ratio;

      dot2 <= 34'(p0) + 34'(p1) + 34'(p2);
      n2r  <= n1;

      c3   <= c_conv;
      lv3  <= !dot2[33] && (dot2 != '0);
      n3   <= n2r;

      cc4  <= 62'(c3) * 62'(c3);
      nn4  <= 30'(n3) * 30'(n3);
      c4   <= c3;
      n4   <= n3;
      lv4  <= lv3;

      s5   <= ONE30 - 31'(cc4 >> 30);
      nn5  <= nn4;
      c5   <= c4;
      n5   <= n4;
      lv5  <= lv4;

      // When entering, the quotient reaches 1.0 exactly when the top of the
      // dividend is no smaller than the divisor.
      sn6  <= 61'(s5) * 61'(nn5);
      te6  <= (n5 == '0) || (!lv5 && ({5'b0, s5[30:6]} >= nn5));
      s6   <= s5;
      nn6  <= nn5;
      c6   <= c5;
      n6   <= n5;
      lv6  <= lv5;
    end
  end

  // Refraction divide.
  div1_side_t  d1_in, d1_out;
  logic        tir6;
  logic [29:0] d1_rem;
  logic        d1_valid;
  logic [29:0] q_div;

  always_comb begin
    tir6          = te6 || (lv6 && (sn6[60:54] != '0));
    d1_rem        = (tir6 || lv6) ? '0 : {5'b0, s6[30:6]};
    d1_in.c       = c6;
    d1_in.n       = n6;
    d1_in.leaving = lv6;
    d1_in.tir     = tir6;
    d1_in.qlv     = sn6[53:24];
  end

  fr_div #(
    .DW(Q_BITS),
    .QB(Q_BITS),
    .SW($bits(div1_side_t))
  ) u_div_q (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .rem_in   (d1_rem),
    .div_in   (nn6),
    .low_in   ({s6[5:0], 24'b0}),
    .side_in  (d1_in),
    .out_valid(d1_valid),
    .quot     (q_div),
    .side_out (d1_out)
  );

  // Stage 7: squared transmitted cosine.
  logic        v7;
  logic [30:0] m7;
  root_side_t  rs7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= d1_valid;
    end
    if (en) begin
      m7     <= ONE30 - {1'b0, (d1_out.leaving ? d1_out.qlv : q_div)};
      rs7.c  <= d1_out.c;
      rs7.n  <= d1_out.n;
      rs7.tir <= d1_out.tir;
    end
  end

  logic        sq_valid;
  logic [30:0] ct_root;
  root_side_t  rs_out;

  fr_sqrt #(
    .RB(ROOT_BITS),
    .SW($bits(root_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .rad_in   ({1'b0, m7, 30'b0}),
    .side_in  (rs7),
    .out_valid(sq_valid),
    .root     (ct_root),
    .side_out (rs_out)
  );

  // Stage 8: index-scaled cosines.
  logic        v8, tir8;
  logic [32:0] rc8, rt8;
  logic [30:0] c8, ct8;
  // Stage 9: numerators and denominators of both coefficients.
  logic        v9, tir9;
  logic [33:0] na9, da9, nb9, db9;

  logic [32:0] diff_a, diff_b;

  always_comb begin
    diff_a = (rc8 > 33'(ct8)) ? rc8 - 33'(ct8) : 33'(ct8) - rc8;
    diff_b = (33'(c8) > rt8) ? 33'(c8) - rt8 : rt8 - 33'(c8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v8 <= sq_valid;
      v9 <= v8;
    end
    if (en) begin
      rc8  <= 33'((46'(rs_out.n) * 46'(rs_out.c)) >> 12);
      rt8  <= 33'((46'(rs_out.n) * 46'(ct_root)) >> 12);
      c8   <= rs_out.c;
      ct8  <= ct_root;
      tir8 <= rs_out.tir;

      // Under total reflection the dividers get a harmless zero over one.
      na9  <= tir8 ? '0 : 34'(diff_a);
      da9  <= tir8 ? 34'd1 : 34'(rc8) + 34'(ct8);
      nb9  <= tir8 ? '0 : 34'(diff_b);
      db9  <= tir8 ? 34'd1 : 34'(c8) + 34'(rt8);
      tir9 <= tir8;
    end
  end

  logic        va, vb, ta, tb;
  logic [30:0] qa, qb;

  fr_div #(
    .DW(34),
    .QB(31),
    .SW(1)
  ) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v9),
    .rem_in   (na9 >> 1),
    .div_in   (da9),
    .low_in   ({na9[0], 30'b0}),
    .side_in  (tir9),
    .out_valid(va),
    .quot     (qa),
    .side_out (ta)
  );

  fr_div #(
    .DW(34),
    .QB(31),
    .SW(1)
  ) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v9),
    .rem_in   (nb9 >> 1),
    .div_in   (db9),
    .low_in   ({nb9[0], 30'b0}),
    .side_in  (tir9),
    .out_valid(vb),
    .quot     (qb),
    .side_out (tb)
  );

  // Stage 10: squared coefficients; stage 11: mean and output register.
  logic        v10, tir10;
  logic [30:0] aa10, bb10;
  logic [31:0] sum10;
  logic [16:0] r_q16;

  always_comb begin
    sum10 = 32'(aa10) + 32'(bb10);
    r_q16 = 17'(sum10 >> 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v10       <= va && vb;
      out_valid <= v10;
    end
    if (en) begin
      aa10  <= 31'((62'(qa) * 62'(qa)) >> 30);
      bb10  <= 31'((62'(qb) * 62'(qb)) >> 30);
      tir10 <= ta || tb;
      if (tir10 || (r_q16 > REFL_ONE)) begin
        reflectance <= REFL_ONE;
      end else begin
        reflectance <= r_q16;
      end
    end
  end

endmodule
